// ===== src/mid_pkg.sv =====
// Shared types and constants for the multi-input debouncer.
// No dependencies; imported by every module of the block.
package mid_pkg;

  localparam int CHANNELS   = 16;
  localparam int IDX_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W      = 8;
  localparam int REC_W      = 4;
  localparam int GROUP_SIZE = 4;
  localparam int NGROUPS    = (CHANNELS + GROUP_SIZE - 1) / GROUP_SIZE;

  localparam logic [CNT_W-1:0] COUNT_MAX    = 8'hFF;
  localparam logic [CNT_W-1:0] DEFAULT_HOLD = 8'd100;
  localparam logic [CNT_W-1:0] DEFAULT_POLL = 8'd1;

  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_HOLD_MS     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_POLL_MS     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_INVERT_MASK = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ENABLE_MASK = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_GROUP_MASK  = 3'd4;
  localparam int CFG_DATA_W = 16;

  typedef struct packed {
    logic [CHANNELS-1:0] raw_sample;
    logic [CHANNELS-1:0] latch_clear;
    logic [CHANNELS-1:0] flip_clear;
  } in_item_t;

  typedef struct packed {
    logic [CHANNELS-1:0] stable_bits;
    logic [CHANNELS-1:0] rise_latch;
    logic [CHANNELS-1:0] change_flags;
    logic                any_changed;
    logic                group_all_high;
    logic                group_any_high;
    logic [REC_W-1:0]    recent_channel;
  } out_item_t;

  typedef struct packed {
    logic             stable;
    logic             stable_next;
    logic [CNT_W-1:0] active_time;
  } lane_state_t;

  typedef struct packed {
    logic             found;
    logic [CNT_W-1:0] active_time;
    logic [IDX_W-1:0] idx;
  } cand_t;

  typedef struct packed {
    logic             all_high;
    logic             any_high;
    logic [REC_W-1:0] recent;
  } group_res_t;

  // Higher-index candidate wins ties.
  function automatic cand_t pick(input cand_t lo, input cand_t hi);
    cand_t r;
    if (hi.found && (!lo.found || hi.active_time <= lo.active_time)) r = hi;
    else r = lo;
    return r;
  endfunction

endpackage

// ===== src/multi_input_debouncer_core.sv =====
// Multi-input debouncer top level: configuration registers, per-channel lanes,
// sticky flag stores, merge tree and output register. Depends on mid_pkg.
// A tick is registered in the lane state, then in the two merge-tree register stages,
// the last of which feeds the output. Throughput: one tick per cycle while out_stall
// does not back up the pipeline; the stages advance independently.
// Reset (rst, synchronous) clears all lane state, flag stores and valids and
// restores hold 100, poll 10, masks zero.
module multi_input_debouncer_core import mid_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [REG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_item_t               in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_item_t              out_data
);

  logic [CNT_W-1:0]    hold_ms;
  logic [CNT_W-1:0]    poll_ms;
  logic [CHANNELS-1:0] invert_mask;
  logic [CHANNELS-1:0] enable_mask;
  logic [CHANNELS-1:0] group_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_ms <= DEFAULT_HOLD;
      poll_ms <= 8'd10;
      invert_mask <= '0;
      enable_mask <= '0;
      group_mask <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HOLD_MS:     hold_ms <= cfg_data[CNT_W-1:0];
        REG_POLL_MS:     poll_ms <= cfg_data[CNT_W-1:0];
        REG_INVERT_MASK: invert_mask <= cfg_data[CHANNELS-1:0];
        REG_ENABLE_MASK: enable_mask <= cfg_data[CHANNELS-1:0];
        REG_GROUP_MASK:  group_mask <= cfg_data[CHANNELS-1:0];
        default: ;
      endcase
    end
  end

  logic [CNT_W-1:0] poll_eff;
  logic [CNT_W-1:0] hold_eff;
  logic [CNT_W+1:0] start_sum;
  logic [CNT_W-1:0] start;

  always_comb begin
    poll_eff = (poll_ms == '0) ? DEFAULT_POLL : poll_ms;
    hold_eff = (hold_ms == '0) ? DEFAULT_HOLD : hold_ms;
    start_sum = {2'b00, hold_eff} + {2'b00, poll_eff} + 10'd1;
    start = (start_sum > {2'b00, COUNT_MAX}) ? COUNT_MAX : start_sum[CNT_W-1:0];
  end

  // pipeline control: s1 = lane state holds an unmerged tick, s2 = merge mid-stage
  logic s1_valid, s2_valid;
  logic en0, en1, en2, accept;

  assign en2 = !out_valid || !out_stall;
  assign en1 = !s2_valid || en2;
  assign en0 = !s1_valid || en1;
  assign in_stall = !en0;
  assign accept = in_valid && en0;

  lane_state_t         lane [CHANNELS];
  logic [CHANNELS-1:0] stable;
  logic [CHANNELS-1:0] stable_next;
  logic [CNT_W-1:0]    active_time [CHANNELS];

  for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
    mid_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .step   (accept & enable_mask[i]),
      .sample (in_data.raw_sample[i]),
      .invert (invert_mask[i]),
      .start  (start),
      .poll   (poll_eff),
      .state  (lane[i])
    );
    assign stable[i] = lane[i].stable;
    assign stable_next[i] = lane[i].stable_next;
    assign active_time[i] = lane[i].active_time;
  end

  logic [CHANNELS-1:0] rise_store;
  logic [CHANNELS-1:0] change_store;
  logic                s1_any;

  always_ff @(posedge clk) begin
    if (rst) begin
      rise_store <= '0;
      change_store <= '0;
    end else if (accept) begin
      rise_store <= (rise_store & ~in_data.latch_clear) | (stable_next & ~stable);
      change_store <= (change_store & ~in_data.flip_clear) | (stable_next ^ stable);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) s1_any <= (stable_next != stable);
  end

  group_res_t grp;

  mid_merge u_merge (
    .clk         (clk),
    .en1         (en1),
    .en2         (en2),
    .group_mask  (group_mask),
    .stable      (stable),
    .active_time (active_time),
    .res         (grp)
  );

  logic [CHANNELS-1:0] s2_stable, s2_rise, s2_change;
  logic                s2_any;
  logic [CHANNELS-1:0] o_stable, o_rise, o_change;
  logic                o_any;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en0) s1_valid <= in_valid;
      if (en1) s2_valid <= s1_valid;
      if (en2) out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s2_stable <= stable;
      s2_rise <= rise_store;
      s2_change <= change_store;
      s2_any <= s1_any;
    end
    if (en2) begin
      o_stable <= s2_stable;
      o_rise <= s2_rise;
      o_change <= s2_change;
      o_any <= s2_any;
    end
  end

  always_comb begin
    out_data.stable_bits = o_stable;
    out_data.rise_latch = o_rise;
    out_data.change_flags = o_change;
    out_data.any_changed = o_any;
    out_data.group_all_high = grp.all_high;
    out_data.group_any_high = grp.any_high;
    out_data.recent_channel = grp.recent;
  end

endmodule

// ===== src/mid_lane.sv =====
// One debounce channel: raw tracking, hold countdown, stable level, active time.
// Depends on mid_pkg.
module mid_lane import mid_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic             sample,
  input  logic             invert,
  input  logic [CNT_W-1:0] start,
  input  logic [CNT_W-1:0] poll,
  output lane_state_t      state
);

  logic             raw;
  logic             stable;
  logic [CNT_W-1:0] hold;
  logic [CNT_W-1:0] active_time;

  logic             v;
  logic             raw_next;
  logic             stable_next;
  logic [CNT_W-1:0] hold_pre;
  logic [CNT_W-1:0] hold_next;
  logic [CNT_W-1:0] active_time_next;

  always_comb begin
    v = sample ^ invert;
    raw_next = v;
    hold_pre = (v != raw) ? start : hold;
    stable_next = stable;
    hold_next = '0;
    if (hold_pre != '0) begin
      hold_next = (hold_pre < poll) ? '0 : hold_pre - poll;
      if (hold_next == '0) stable_next = v;
    end
    if (!stable_next) active_time_next = '0;
    else if (active_time == COUNT_MAX) active_time_next = active_time;
    else active_time_next = active_time + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw <= 1'b0;
      stable <= 1'b0;
      hold <= '0;
      active_time <= '0;
    end else if (step) begin
      raw <= raw_next;
      stable <= stable_next;
      hold <= hold_next;
      active_time <= active_time_next;
    end
  end

  assign state.stable      = stable;
  assign state.stable_next = step ? stable_next : stable;
  assign state.active_time = active_time;

endmodule

// ===== src/mid_merge.sv =====
// Group queries over all lanes: all/any high and most recent activation,
// as a two-level registered tree. Depends on mid_pkg.
module mid_merge import mid_pkg::*; (
  input  logic                clk,
  input  logic                en1,
  input  logic                en2,
  input  logic [CHANNELS-1:0] group_mask,
  input  logic [CHANNELS-1:0] stable,
  input  logic [CNT_W-1:0]    active_time [CHANNELS],
  output group_res_t          res
);

  cand_t grp_best [NGROUPS];
  cand_t grp_best_next [NGROUPS];
  logic  all_s2;
  logic  any_s2;
  cand_t final_best;

  always_comb begin
    cand_t c;
    c = '0;
    for (int g = 0; g < NGROUPS; g++) begin
      grp_best_next[g] = '0;
      for (int j = 0; j < GROUP_SIZE; j++) begin
        if (g * GROUP_SIZE + j < CHANNELS) begin
          c.found = group_mask[g * GROUP_SIZE + j] & stable[g * GROUP_SIZE + j];
          c.active_time = active_time[g * GROUP_SIZE + j];
          c.idx = IDX_W'(g * GROUP_SIZE + j);
          grp_best_next[g] = pick(grp_best_next[g], c);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      grp_best <= grp_best_next;
      all_s2 <= &(~group_mask | stable);
      any_s2 <= |(group_mask & stable);
    end
  end

  always_comb begin
    final_best = '0;
    for (int g = 0; g < NGROUPS; g++) final_best = pick(final_best, grp_best[g]);
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      res.all_high <= all_s2;
      res.any_high <= any_s2;
      res.recent <= final_best.found ? REC_W'(final_best.idx) : '0;
    end
  end

endmodule

// ===== src/mid_checker.sv =====
// Port-level checks for the debouncer top level, plus the bind that attaches them.
// Depends on mid_pkg and multi_input_debouncer_core.
module mid_checker import mid_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_change_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.any_changed |-> out_data.change_flags != '0)
    else $error("stable change without change flag");

  a_recent_none: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.group_any_high |-> out_data.recent_channel == '0)
    else $error("recent channel set with no group channel high");

endmodule

bind multi_input_debouncer_core mid_checker u_mid_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== sim/testbench.sv =====
// Self-checking testbench for multi_input_debouncer_core: directed and random poll ticks,
// a scoreboard class that predicts each result, and random sender and receiver idling.
// Depends on mid_pkg and the block's RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mid_pkg::*;

  class debounce_scoreboard;
    logic [CNT_W-1:0]    hold_ms, poll_ms;
    logic [CHANNELS-1:0] invert_mask, enable_mask, group_mask;
    logic [CHANNELS-1:0] raw_level, stable_level, rise_store, change_store;
    logic [CNT_W-1:0]    hold_count [CHANNELS];
    logic [CNT_W-1:0]    active_time [CHANNELS];
    out_item_t           expected_q[$];
    int                  errors;

    function new();
      hold_ms = DEFAULT_HOLD;
      poll_ms = 8'd10;
      invert_mask = '0;
      enable_mask = '0;
      group_mask = '0;
      raw_level = '0;
      stable_level = '0;
      rise_store = '0;
      change_store = '0;
      for (int i = 0; i < CHANNELS; i++) begin
        hold_count[i] = '0;
        active_time[i] = '0;
      end
      errors = 0;
    endfunction

    function void set_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_HOLD_MS:     hold_ms = val[CNT_W-1:0];
        REG_POLL_MS:     poll_ms = val[CNT_W-1:0];
        REG_INVERT_MASK: invert_mask = val[CHANNELS-1:0];
        REG_ENABLE_MASK: enable_mask = val[CHANNELS-1:0];
        REG_GROUP_MASK:  group_mask = val[CHANNELS-1:0];
        default: ;
      endcase
    endfunction

    // Advance the debounce state by one poll tick and queue the result it yields.
    function void note_tick(input in_item_t tick);
      int unsigned         poll, hold, start, best;
      logic [CHANNELS-1:0] was;
      logic                v;
      out_item_t           r;
      poll = (poll_ms != 0) ? poll_ms : 1;
      hold = (hold_ms != 0) ? hold_ms : 100;
      start = hold + poll + 1;
      if (start > 255) start = 255;
      was = stable_level;
      rise_store &= ~tick.latch_clear;
      change_store &= ~tick.flip_clear;
      for (int i = 0; i < CHANNELS; i++) begin
        if (enable_mask[i]) begin
          v = tick.raw_sample[i] ^ invert_mask[i];
          if (v != raw_level[i]) begin
            raw_level[i] = v;
            hold_count[i] = CNT_W'(start);
          end
          if (hold_count[i] != 0) begin
            if (hold_count[i] < poll) hold_count[i] = '0;
            else hold_count[i] = hold_count[i] - CNT_W'(poll);
            if (hold_count[i] == 0) stable_level[i] = v;
          end
          if (!stable_level[i]) active_time[i] = '0;
          else if (active_time[i] != COUNT_MAX) active_time[i] = active_time[i] + 1'b1;
        end
      end
      rise_store |= stable_level & ~was;
      change_store |= stable_level ^ was;

      r = '0;
      r.stable_bits = stable_level;
      r.rise_latch = rise_store;
      r.change_flags = change_store;
      r.any_changed = (stable_level != was);
      r.group_all_high = 1'b1;
      r.group_any_high = 1'b0;
      best = 255;
      // youngest high group channel; later index wins a tie
      for (int p = 0; p < CHANNELS; p++) begin
        if (group_mask[p]) begin
          if (!stable_level[p]) begin
            r.group_all_high = 1'b0;
          end else begin
            r.group_any_high = 1'b1;
            if (active_time[p] <= best) begin
              best = 32'(active_time[p]);
              r.recent_channel = REC_W'(p);
            end
          end
        end
      end
      expected_q.push_back(r);
    endfunction

    function void check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(input out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none got %0h", $time, got);
        return;
      end
      want = expected_q.pop_front();
      check_field("stable_bits", 32'(want.stable_bits), 32'(got.stable_bits));
      check_field("rise_latch", 32'(want.rise_latch), 32'(got.rise_latch));
      check_field("change_flags", 32'(want.change_flags), 32'(got.change_flags));
      check_field("any_changed", 32'(want.any_changed), 32'(got.any_changed));
      check_field("group_all_high", 32'(want.group_all_high), 32'(got.group_all_high));
      check_field("group_any_high", 32'(want.group_any_high), 32'(got.group_any_high));
      check_field("recent_channel", 32'(want.recent_channel), 32'(got.recent_channel));
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [REG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;

  debounce_scoreboard    sb;
  int                    send_idle_pct = 0;
  int                    stall_pct = 0;
  bit                    long_hold = 1'b0;
  logic [CHANNELS-1:0]   level_now = '0;

  multi_input_debouncer_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver: random stalls, or one long hold-off when requested.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        long_hold = 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_tick(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  initial begin
    #2000000;
    $display("testbench: errors");
    $finish;
  end

  function automatic in_item_t make_tick(input logic [CHANNELS-1:0] raw,
                                         input logic [CHANNELS-1:0] lclr,
                                         input logic [CHANNELS-1:0] fclr);
    in_item_t t;
    t.raw_sample = raw;
    t.latch_clear = lclr;
    t.flip_clear = fclr;
    return t;
  endfunction

  function automatic logic [CHANNELS-1:0] clear_mask();
    case ($urandom_range(9))
      0:       return '1;
      1:       return CHANNELS'($urandom);
      2, 3:    return '0;
      default: return CHANNELS'($urandom & $urandom & $urandom);
    endcase
  endfunction

  task automatic write_one(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic load_config(input logic [7:0] hold, input logic [7:0] poll,
                             input logic [15:0] inv, input logic [15:0] en,
                             input logic [15:0] grp);
    write_one(REG_HOLD_MS, {8'h00, hold});
    write_one(REG_POLL_MS, {8'h00, poll});
    write_one(REG_INVERT_MASK, inv);
    write_one(REG_ENABLE_MASK, en);
    write_one(REG_GROUP_MASK, grp);
    cfg_we <= 1'b0;
  endtask

  task automatic send_tick(input in_item_t tick);
    in_data <= tick;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // Let every queued result come out before touching the registers.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Mostly steady raw levels in segments near the settle time, a few bits moving at a
  // time, with one-tick glitches on top.
  task automatic run_phase(input int n_ticks, input int idle_pct, input int hold_pct,
                           input bit pressure);
    int                  hold_v, poll_v, start_v, settle, seg_left, seg_max;
    logic [CHANNELS-1:0] raw, flips;
    send_idle_pct = idle_pct;
    stall_pct = hold_pct;
    if (pressure) long_hold = 1'b1;
    hold_v = (sb.hold_ms != 0) ? sb.hold_ms : 100;
    poll_v = (sb.poll_ms != 0) ? sb.poll_ms : 1;
    start_v = (hold_v + poll_v + 1 > 255) ? 255 : hold_v + poll_v + 1;
    settle = (start_v + poll_v - 1) / poll_v;
    seg_max = (2 * settle + 2 < 40) ? 2 * settle + 2 : 40;
    seg_left = 0;
    for (int k = 0; k < n_ticks; k++) begin
      if (seg_left == 0) begin
        if ($urandom_range(99) < 4) seg_left = settle + $urandom_range(0, 10);
        else seg_left = $urandom_range(1, seg_max);
        case ($urandom_range(9))
          0:       flips = CHANNELS'($urandom);
          1:       flips = '1;
          default: flips = (CHANNELS'(1) << $urandom_range(CHANNELS - 1)) |
                           (($urandom_range(3) == 0) ?
                            (CHANNELS'(1) << $urandom_range(CHANNELS - 1)) : '0);
        endcase
        level_now ^= flips;
      end
      seg_left--;
      raw = level_now;
      if ($urandom_range(99) < 5) raw ^= CHANNELS'($urandom & $urandom);
      send_tick(make_tick(raw, clear_mask(), clear_mask()));
    end
    drain();
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_HOLD_MS;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // instant settle, empty group
    load_config(8'd1, 8'd255, 16'h0000, 16'hFFFF, 16'h0000);
    send_tick(make_tick(16'h0000, 16'h0000, 16'h0000));
    send_tick(make_tick(16'hFFFF, 16'h0000, 16'h0000));
    send_tick(make_tick(16'hFFFF, 16'h0000, 16'h0000));
    send_tick(make_tick(16'hFFFF, 16'hFFFF, 16'h0000));
    send_tick(make_tick(16'h0000, 16'h0000, 16'hFFFF));
    // clear and a new edge on the same tick
    send_tick(make_tick(16'h0001, 16'hFFFF, 16'hFFFF));
    send_tick(make_tick(16'h8000, 16'h0000, 16'h0000));
    send_tick(make_tick(16'hAAAA, 16'h0000, 16'h0000));
    send_tick(make_tick(16'h5555, 16'h0000, 16'h0000));
    drain();

    // upper byte disabled and frozen, full group, hold zero means default
    load_config(8'd0, 8'd255, 16'hFF00, 16'h00FF, 16'hFFFF);
    send_tick(make_tick(16'h00FF, 16'h0000, 16'h0000));
    send_tick(make_tick(16'hFF00, 16'h0000, 16'h0000));
    send_tick(make_tick(16'h0080, 16'h0000, 16'h0000));
    send_tick(make_tick(16'h0081, 16'h0000, 16'h0000));
    send_tick(make_tick(16'h0083, 16'h0000, 16'h0000));
    drain();

    // everything inverted; several channels rising together tie on active time
    load_config(8'd255, 8'd255, 16'hFFFF, 16'hFFFF, 16'hF0F0);
    send_tick(make_tick(16'h0000, 16'h0000, 16'h0000));
    send_tick(make_tick(16'hFFFF, 16'h0000, 16'h0000));
    send_tick(make_tick(16'h0F0F, 16'h0000, 16'h0000));
    send_tick(make_tick(16'h0F0F, 16'h0000, 16'h0000));
    drain();

    // real countdown: a glitch restarts it, then four steady ticks settle
    load_config(8'd20, 8'd10, 16'h0000, 16'hFFFF, 16'h000F);
    send_tick(make_tick(16'h0001, 16'h0000, 16'h0000));
    send_tick(make_tick(16'h0000, 16'h0000, 16'h0000));
    repeat (4) send_tick(make_tick(16'h0001, 16'h0000, 16'h0000));
    drain();

    level_now = 16'h0001;
    load_config(8'd0, 8'd10, 16'h0000, 16'hFFFF, 16'hFFFF);
    run_phase(200, 0, 0, 1'b0);
    load_config(8'd255, 8'd1, 16'($urandom), 16'hFFFF, 16'($urandom));
    run_phase(200, 76, 0, 1'b0);
    load_config(8'd1, 8'd255, 16'hFFFF, 16'($urandom), 16'h0000);
    run_phase(200, 0, 76, 1'b0);
    load_config(8'($urandom_range(0, 255)), 8'($urandom_range(1, 255)), 16'($urandom),
                16'($urandom), 16'($urandom));
    run_phase(200, 30, 30, 1'b0);
    load_config(8'd100, 8'd40, 16'($urandom), 16'hFFFF, 16'($urandom));
    run_phase(200, 0, 0, 1'b1);
    load_config(8'd0, 8'd1, 16'h0000, 16'hFFFF, 16'hFFFF);
    run_phase(200, 76, 0, 1'b0);
    load_config(8'($urandom_range(0, 255)), 8'($urandom_range(1, 255)), 16'($urandom),
                16'h0000, 16'($urandom));
    run_phase(120, 0, 76, 1'b0);
    load_config(8'($urandom_range(0, 255)), 8'($urandom_range(1, 255)), 16'($urandom),
                16'($urandom), 16'($urandom));
    run_phase(200, 30, 30, 1'b0);

    if (sb.errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
